>>> design/dbcm_pkg.sv
// ----------------------------------------------------------------------------
// dbcm_pkg
// Shared types, constants and the log2 fraction generator for the decibel
// colormap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dbcm_pkg;

	localparam int NUM_STG = 10;

	localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394567;
	localparam int          ATT_SHIFT      = 24;

	localparam logic [7:0]  FLOOR_RST      = 8'd100;
	localparam logic [23:0] COLOR_LOW_RST  = 24'h000000;
	localparam logic [23:0] COLOR_MID_RST  = 24'h8000FF;
	localparam logic [23:0] COLOR_HIGH_RST = 24'hFFFF00;

	typedef enum logic [1:0] {
		REG_NOISE_FLOOR = 2'd0,
		REG_COLOR_LOW   = 2'd1,
		REG_COLOR_MID   = 2'd2,
		REG_COLOR_HIGH  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  floor_db;
		logic [31:0] recip;
		logic [23:0] low;
		logic [23:0] mid;
		logic [23:0] high;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STG-1:0] en;
	} stg_en_t;

	typedef struct packed {
		logic zero;
		logic full;
	} mag_flags_t;

	// log2(1 + i / 2^bits) in Q0.16 by squaring digit recurrence
	function automatic logic [15:0] log2_frac(int unsigned i, int unsigned bits);
		logic [63:0] y;
		logic [15:0] r;
		int          k;
		y = (64'd1 << 30) + (64'(i) << (30 - bits));
		r = '0;
		for (k = 0; k < 16; k++) begin
			y = (y * y) >> 30;
			r = {r[14:0], 1'b0};
			if (y >= (64'd2 << 30)) begin
				r[0] = 1'b1;
				y    = y >> 1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/dbcm_ctrl.sv
// ----------------------------------------------------------------------------
// dbcm_ctrl
// Per-stage valid bits and load enables; a stage loads when it is empty or
// the stage after it moves.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dbcm_pkg::stg_en_t      stg
);
	import dbcm_pkg::*;

	logic [NUM_STG-1:0] vld_q;

	always_comb begin
		stg.en[NUM_STG-1] = !vld_q[NUM_STG-1] || !out_stall;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			stg.en[k] = !vld_q[k] || stg.en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stg.en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (stg.en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !stg.en[0];
	assign out_valid = vld_q[NUM_STG-1];

endmodule

`default_nettype wire

>>> design/dbcm_log.sv
// ----------------------------------------------------------------------------
// dbcm_log
// Stages 1 to 4: leading-zero count, normalize, log2 fraction lookup and
// scaling of the octave attenuation to decibels.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_log #(
	parameter int MAG_WIDTH      = 32,
	parameter int LOG_TABLE_BITS = 6,
	parameter int LZ_W           = 5,
	parameter int PROD_W         = 40
) (
	input  wire logic                   clk,
	input  wire dbcm_pkg::stg_en_t      stg,
	input  wire logic [MAG_WIDTH-1:0]   magnitude,
	output logic [PROD_W-1:0]           prod_s4,
	output dbcm_pkg::mag_flags_t        flg_s4
);
	import dbcm_pkg::*;

	localparam int A_W = LZ_W + 16;

	logic [15:0] lut [2**LOG_TABLE_BITS];

	for (genvar g = 0; g < 2**LOG_TABLE_BITS; g++) begin : g_lut
		localparam logic [15:0] LV = log2_frac(g, LOG_TABLE_BITS);
		assign lut[g] = LV;
	end

	logic [LZ_W-1:0]           lz;
	logic [MAG_WIDTH-1:0]      x_s1;
	logic [LZ_W-1:0]           lz_s1, lz_s2, lz_s3;
	mag_flags_t                flg_s1, flg_s2, flg_s3;
	logic [MAG_WIDTH-1:0]      norm;
	logic [LOG_TABLE_BITS-1:0] idx_s2;
	logic [15:0]               frac_s3;
	logic [A_W-1:0]            att_oct;

	always_comb begin
		lz = '0;
		for (int i = 0; i < MAG_WIDTH; i++) begin
			if (magnitude[i]) begin
				lz = LZ_W'(MAG_WIDTH - 1 - i);
			end
		end
	end

	assign norm    = x_s1 << lz_s1;
	assign att_oct = {lz_s3, 16'b0} - {{LZ_W{1'b0}}, frac_s3};

	always_ff @(posedge clk) begin
		if (stg.en[0]) begin
			x_s1        <= magnitude;
			lz_s1       <= lz;
			flg_s1.zero <= ~|magnitude;
			flg_s1.full <= magnitude[MAG_WIDTH-1];
		end
		if (stg.en[1]) begin
			idx_s2 <= norm[MAG_WIDTH-2 -: LOG_TABLE_BITS];
			lz_s2  <= lz_s1;
			flg_s2 <= flg_s1;
		end
		if (stg.en[2]) begin
			frac_s3 <= lut[idx_s2];
			lz_s3   <= lz_s2;
			flg_s3  <= flg_s2;
		end
		if (stg.en[3]) begin
			prod_s4 <= PROD_W'(att_oct) * PROD_W'(DB_PER_OCT_Q16);
			flg_s4  <= flg_s3;
		end
	end

endmodule

`default_nettype wire

>>> design/dbcm_frac.sv
// ----------------------------------------------------------------------------
// dbcm_frac
// Stages 5 to 8: saturate the decibel attenuation, divide by the floor
// through its reciprocal with one correction step, and form the blend
// weight and segment.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_frac #(
	parameter int PROD_W = 40
) (
	input  wire logic                 clk,
	input  wire dbcm_pkg::stg_en_t    stg,
	input  wire dbcm_pkg::cfg_t       cfg,
	input  wire logic [PROD_W-1:0]    prod_s4,
	input  wire dbcm_pkg::mag_flags_t flg_s4,
	output logic [16:0]               t_s8,
	output logic                      hi_s8
);
	import dbcm_pkg::*;

	logic [PROD_W-1:0] att_raw;
	logic [15:0]       att;
	logic [15:0]       att_s5;
	logic              kill_s5, kill_s6, kill_s7;
	logic              full_s5, full_s6, full_s7;
	logic [55:0]       quo_full;
	logic [23:0]       num_s6;
	logic [15:0]       q_s6, q_s7;
	logic [23:0]       qd;
	logic [23:0]       r_s7;
	logic [16:0]       q_fin;
	logic [16:0]       n;

	assign att_raw  = prod_s4 >> ATT_SHIFT;
	assign att      = (|att_raw[PROD_W-1:16]) ? 16'hFFFF : att_raw[15:0];
	assign quo_full = 56'({att_s5, 8'b0}) * 56'(cfg.recip);
	assign qd       = 24'(q_s6) * 24'(cfg.floor_db);
	assign q_fin    = {1'b0, q_s7} + 17'(r_s7 >= {16'b0, cfg.floor_db});

	always_comb begin
		if (full_s7) begin
			n = 17'h10000;
		end else if (kill_s7) begin
			n = '0;
		end else begin
			n = 17'h10000 - q_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (stg.en[4]) begin
			att_s5  <= att;
			kill_s5 <= flg_s4.zero || (att >= {cfg.floor_db, 8'b0});
			full_s5 <= flg_s4.full;
		end
		if (stg.en[5]) begin
			num_s6  <= {att_s5, 8'b0};
			q_s6    <= quo_full[47:32];
			kill_s6 <= kill_s5;
			full_s6 <= full_s5;
		end
		if (stg.en[6]) begin
			r_s7    <= num_s6 - qd;
			q_s7    <= q_s6;
			kill_s7 <= kill_s6;
			full_s7 <= full_s6;
		end
		if (stg.en[7]) begin
			t_s8  <= {n[16], n[14:0], 1'b0};
			hi_s8 <= n[16] || n[15];
		end
	end

endmodule

`default_nettype wire

>>> design/dbcm_blend.sv
// ----------------------------------------------------------------------------
// dbcm_blend
// Stages 9 and 10: per-channel linear blend between two color stops,
// truncate and clamp to eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_blend (
	input  wire logic              clk,
	input  wire dbcm_pkg::stg_en_t stg,
	input  wire dbcm_pkg::cfg_t    cfg,
	input  wire logic [16:0]       t_s8,
	input  wire logic              hi_s8,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);
	import dbcm_pkg::*;

	logic [23:0]        c0_all, c1_all;
	logic [7:0]         c0 [3];
	logic [7:0]         c1 [3];
	logic signed [8:0]  diff [3];
	logic signed [26:0] prod [3];
	logic signed [26:0] prod_s9 [3];
	logic [7:0]         c0_s9 [3];
	logic signed [27:0] v [3];
	logic [7:0]         chan [3];
	logic [7:0]         rgb_s10 [3];

	assign c0_all = hi_s8 ? cfg.mid  : cfg.low;
	assign c1_all = hi_s8 ? cfg.high : cfg.mid;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			c0[ch]   = c0_all[23 - 8*ch -: 8];
			c1[ch]   = c1_all[23 - 8*ch -: 8];
			diff[ch] = $signed({1'b0, c1[ch]}) - $signed({1'b0, c0[ch]});
			prod[ch] = $signed({1'b0, t_s8}) * diff[ch];
			v[ch]    = $signed({4'b0, c0_s9[ch], 16'b0}) + 28'(prod_s9[ch]);
			if (v[ch][27]) begin
				chan[ch] = 8'd0;
			end else if (|v[ch][26:24]) begin
				chan[ch] = 8'd255;
			end else begin
				chan[ch] = v[ch][23:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (stg.en[8]) begin
				prod_s9[ch] <= prod[ch];
				c0_s9[ch]   <= c0[ch];
			end
			if (stg.en[9]) begin
				rgb_s10[ch] <= chan[ch];
			end
		end
	end

	assign red   = rgb_s10[0];
	assign green = rgb_s10[1];
	assign blue  = rgb_s10[2];

endmodule

`default_nettype wire

>>> design/db_magnitude_colormap_core.sv
// ----------------------------------------------------------------------------
// db_magnitude_colormap_core
// Maps a spectral magnitude to an RGB888 color through a decibel scale and a
// three-stop gradient.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    magnitude
//   out      source     out_valid/out_stall  red, green, blue
//   cfg      sink       cfg_wen              cfg_idx, cfg_wdata
//
// Ten register stages; one item per cycle when not stalled. The count is set
// by the log, divide-by-reciprocal and blend multipliers, each followed by
// a register.
// Reset clears all valid bits and loads the default floor and colors.
// A stall at the output fills empty stages first; the input stalls only when
// all ten stages hold an item.
// ----------------------------------------------------------------------------
`default_nettype none

module db_magnitude_colormap_core #(
	parameter int MAG_WIDTH      = 32,
	parameter int LOG_TABLE_BITS = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [MAG_WIDTH-1:0] magnitude,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	input  wire logic                 cfg_wen,
	input  wire logic [1:0]           cfg_idx,
	input  wire logic [23:0]          cfg_wdata
);
	import dbcm_pkg::*;

	localparam int          LZ_W      = $clog2(MAG_WIDTH);
	localparam int          PROD_W    = LZ_W + 16 + 19;
	localparam logic [31:0] RECIP_RST = 32'(64'hFFFF_FFFF / FLOOR_RST);

	logic [31:0] recip_tab [256];

	for (genvar g = 0; g < 256; g++) begin : g_recip
		localparam logic [31:0] RV = 32'(64'hFFFF_FFFF / ((g == 0) ? 1 : g));
		assign recip_tab[g] = RV;
	end

	logic [7:0]  floor_q;
	logic [31:0] recip_q;
	logic [23:0] low_q, mid_q, high_q;
	cfg_t        cfg;
	stg_en_t     stg;
	logic [PROD_W-1:0] prod_s4;
	mag_flags_t  flg_s4;
	logic [16:0] t_s8;
	logic        hi_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RST;
			recip_q <= RECIP_RST;
			low_q   <= COLOR_LOW_RST;
			mid_q   <= COLOR_MID_RST;
			high_q  <= COLOR_HIGH_RST;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_NOISE_FLOOR: begin
					floor_q <= cfg_wdata[7:0];
					recip_q <= recip_tab[cfg_wdata[7:0]];
				end
				REG_COLOR_LOW:  low_q  <= cfg_wdata;
				REG_COLOR_MID:  mid_q  <= cfg_wdata;
				REG_COLOR_HIGH: high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.floor_db = floor_q;
		cfg.recip    = recip_q;
		cfg.low      = low_q;
		cfg.mid      = mid_q;
		cfg.high     = high_q;
	end

	dbcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stg       (stg)
	);

	dbcm_log #(
		.MAG_WIDTH      (MAG_WIDTH),
		.LOG_TABLE_BITS (LOG_TABLE_BITS),
		.LZ_W           (LZ_W),
		.PROD_W         (PROD_W)
	) u_log (
		.clk       (clk),
		.stg       (stg),
		.magnitude (magnitude),
		.prod_s4   (prod_s4),
		.flg_s4    (flg_s4)
	);

	dbcm_frac #(
		.PROD_W (PROD_W)
	) u_frac (
		.clk     (clk),
		.stg     (stg),
		.cfg     (cfg),
		.prod_s4 (prod_s4),
		.flg_s4  (flg_s4),
		.t_s8    (t_s8),
		.hi_s8   (hi_s8)
	);

	dbcm_blend u_blend (
		.clk   (clk),
		.stg   (stg),
		.cfg   (cfg),
		.t_s8  (t_s8),
		.hi_s8 (hi_s8),
		.red   (red),
		.green (green),
		.blue  (blue)
	);

endmodule

`default_nettype wire

>>> design/dbcm_chk.sv
// ----------------------------------------------------------------------------
// dbcm_chk
// Port-level checks: items in flight, stall behavior, payload hold and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_chk #(
	parameter int MAG_WIDTH = 32
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [MAG_WIDTH-1:0] magnitude,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [7:0]           red,
	input wire logic [7:0]           green,
	input wire logic [7:0]           blue,
	input wire logic                 cfg_wen
);
	import dbcm_pkg::*;

	localparam int CNT_W = $clog2(NUM_STG + 1);

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] inflight_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q <= CNT_W'(NUM_STG)) && (!out_valid || inflight_q != '0))
		else $error("items in flight out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (inflight_q == CNT_W'(NUM_STG)) && out_valid && out_stall)
		else $error("input stalled while a stage is free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("stalled result changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(magnitude))
		else $error("stalled input item changed");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |-> (inflight_q == '0) && !in_acc)
		else $error("configuration written with items in flight");

endmodule

bind db_magnitude_colormap_core dbcm_chk #(
	.MAG_WIDTH (MAG_WIDTH)
) u_dbcm_chk (.*);

`default_nettype wire
